FILE: rtl/masked_bitplane_aes_ctr_unit_assert.svh
// assertion macros for the masked bit-plane aes ctr unit
// expects clk and rst_n in the scope of the module that uses them
`ifndef MASKED_BITPLANE_AES_CTR_UNIT_ASSERT_SVH
`define MASKED_BITPLANE_AES_CTR_UNIT_ASSERT_SVH

// same-cycle implication
`define MBAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbac_pkg.sv
// types, constants and aes round functions for the masked bit-plane aes ctr unit
// no dependencies
`default_nettype none

package mbac_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int BLK_BITS   = 128;

  typedef enum logic [2:0] {
    REG_KEY_UPPER    = 3'd0,
    REG_KEY_LOWER    = 3'd1,
    REG_IV_UPPER     = 3'd2,
    REG_IV_LOWER     = 3'd3,
    REG_PLANE_MODE   = 3'd4,
    REG_PLANE_SELECT = 3'd5
  } reg_idx_t;

  // one classified byte as it waits between front and back
  typedef struct packed {
    logic [7:0]      data;
    logic [7:0]      en;
    logic [7:0][2:0] idx;
    logic [3:0]      nbits;
    logic            first;
  } qent_t;

  typedef struct packed {
    logic take;
    logic reload;
  } gen_ctl_t;

  typedef struct packed {
    logic         pf_valid;
    logic [127:0] pf;
  } gen_stat_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits in bits 127-8i down to 120-8i
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        u[j+4*c] = t[j + 4*((c+j) & 3)];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        u[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
        u[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
        u[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
        u[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = u[i] ^ rk[127-8*i -: 8];
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
    logic [31:0] tmp, w0, w1, w2, w3;
    tmp = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ tmp;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mbac_in_if.sv
// input channel: channel byte with mask and restart flag
// no dependencies
`default_nettype none

interface mbac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       mask_on;
  logic       first_byte;

  modport source (output valid, output data_byte, output mask_on, output first_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input mask_on, input first_byte,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mbac_out_if.sv
// result channel: processed byte
// no dependencies
`default_nettype none

interface mbac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/masked_bitplane_aes_ctr_unit.sv
// top level of the masked bit-plane aes-128 ctr unit: config registers and wiring
// depends on mbac_pkg, mbac_in_if, mbac_out_if, mbac_front, mbac_queue,
// mbac_aes_core and mbac_back
//
// usage:
//   in_ch carries one image byte per transfer with its mask bit and a restart
//   flag; out_ch returns one processed byte per input byte, in order.
//   registers are written over the cfg_ apb port at byte address 8*index,
//   64-bit data; the user must do so only while the unit is idle (not enforced).
// path: a byte goes through the queue and the output register when keystream
//   is at hand; a byte with the restart flag first reloads the counter from the
//   iv, and the first byte that needs bits of a new block waits for the aes core
//   to make it after the restart or a key write.
// throughput: one byte per cycle sustained while out_ch.ready stays high and no
//   restart comes; the iterative aes core keeps one 128-bit block ahead, so
//   whole-byte mode (16 bytes a block) never waits on it once running.
// reset: counter zero, no keystream held, plane mode off, select 0x80.
// stall: a stalled receiver holds the output register; the two-entry queue
//   keeps taking input until it fills, then in_ch.ready drops.
`default_nettype none

module masked_bitplane_aes_ctr_unit (
  input  logic        clk,
  input  logic        rst_n,
  mbac_in_if.sink     in_ch,
  mbac_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0] key_up_r, key_lo_r, iv_up_r, iv_lo_r;
  logic        mode_r;
  logic [7:0]  sel_r;
  logic        wr;
  logic        key_wr;
  logic [2:0]  ridx;

  mbac_pkg::qent_t     q_wdata, q_head;
  logic                q_push, q_full, q_hv, q_pop;
  mbac_pkg::gen_ctl_t  gctl;
  mbac_pkg::gen_stat_t gstat;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx       = cfg_paddr[5:3];
  assign key_wr     = wr && (ridx == mbac_pkg::REG_KEY_UPPER || ridx == mbac_pkg::REG_KEY_LOWER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_up_r <= '0;
      key_lo_r <= '0;
      iv_up_r  <= '0;
      iv_lo_r  <= '0;
      mode_r   <= 1'b0;
      sel_r    <= 8'h80;
    end else if (wr) begin
      case (ridx)
        mbac_pkg::REG_KEY_UPPER:    key_up_r <= cfg_pwdata;
        mbac_pkg::REG_KEY_LOWER:    key_lo_r <= cfg_pwdata;
        mbac_pkg::REG_IV_UPPER:     iv_up_r  <= cfg_pwdata;
        mbac_pkg::REG_IV_LOWER:     iv_lo_r  <= cfg_pwdata;
        mbac_pkg::REG_PLANE_MODE:   mode_r   <= cfg_pwdata[0];
        mbac_pkg::REG_PLANE_SELECT: sel_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mbac_pkg::REG_KEY_UPPER:    cfg_prdata = key_up_r;
      mbac_pkg::REG_KEY_LOWER:    cfg_prdata = key_lo_r;
      mbac_pkg::REG_IV_UPPER:     cfg_prdata = iv_up_r;
      mbac_pkg::REG_IV_LOWER:     cfg_prdata = iv_lo_r;
      mbac_pkg::REG_PLANE_MODE:   cfg_prdata = {63'd0, mode_r};
      mbac_pkg::REG_PLANE_SELECT: cfg_prdata = {56'd0, sel_r};
      default:                    cfg_prdata = 64'd0;
    endcase
  end

  mbac_front u_front (
    .in_ch        (in_ch),
    .plane_mode   (mode_r),
    .plane_select (sel_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  mbac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .head_valid (q_hv),
    .head       (q_head),
    .pop        (q_pop)
  );

  mbac_aes_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .key    ({key_up_r, key_lo_r}),
    .iv     ({iv_up_r, iv_lo_r}),
    .key_wr (key_wr),
    .ctl    (gctl),
    .stat   (gstat)
  );

  mbac_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_hv),
    .head       (q_head),
    .pop        (q_pop),
    .gstat      (gstat),
    .gctl       (gctl),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/mbac_front.sv
// front end: accepts bytes and works out which keystream bits each one takes
// depends on mbac_pkg and mbac_in_if
`default_nettype none

module mbac_front (
  mbac_in_if.sink          in_ch,
  input  logic             plane_mode,
  input  logic [7:0]       plane_select,
  input  logic             q_full,
  output logic             q_push,
  output mbac_pkg::qent_t  q_wdata
);

  logic [3:0] cnt;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.data  = in_ch.data_byte;
    q_wdata.first = in_ch.first_byte;
    q_wdata.en    = 8'h00;
    q_wdata.idx   = '0;
    q_wdata.nbits = 4'd0;
    cnt           = 4'd0;
    if (!plane_mode) begin
      // whole byte always burns eight bits, msb takes the first
      for (int p = 0; p < 8; p++) begin
        q_wdata.idx[p] = 3'(7 - p);
      end
      q_wdata.en    = in_ch.mask_on ? 8'hff : 8'h00;
      q_wdata.nbits = 4'd8;
    end else if (in_ch.mask_on) begin
      for (int p = 7; p >= 0; p--) begin
        q_wdata.idx[p] = cnt[2:0];
        if (plane_select[p]) begin
          cnt = cnt + 4'd1;
        end
      end
      q_wdata.en    = plane_select;
      q_wdata.nbits = cnt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mbac_queue.sv
// two-entry queue between the front end and the keystream back end
// depends on mbac_pkg
`default_nettype none

module mbac_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbac_pkg::qent_t wdata,
  output logic            full,
  output logic            head_valid,
  output mbac_pkg::qent_t head,
  input  logic            pop
);

  mbac_pkg::qent_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mbac_aes_core.sv
// iterative aes-128 keystream generator, one round per cycle, keeps one block ahead
// depends on mbac_pkg
`default_nettype none

module mbac_aes_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [127:0]        key,
  input  logic [127:0]        iv,
  input  logic                key_wr,
  input  mbac_pkg::gen_ctl_t  ctl,
  output mbac_pkg::gen_stat_t stat
);

  logic [127:0] ctr_r, ctr_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt;
  logic         pfv_r, pfv_nxt;
  logic [127:0] pf_r, pf_nxt;
  logic [127:0] rk_step;
  logic         last;

  assign stat.pf_valid = pfv_r;
  assign stat.pf       = pf_r;

  assign last    = (rnd_r == 4'(mbac_pkg::NUM_ROUNDS));
  assign rk_step = mbac_pkg::key_next(rk_r, rcon_r);

  always_comb begin
    ctr_nxt  = ctr_r;
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    rcon_nxt = rcon_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    pfv_nxt  = pfv_r;
    pf_nxt   = pf_r;
    if (ctl.reload) begin
      ctr_nxt  = iv;
      pfv_nxt  = 1'b0;
      busy_nxt = 1'b0;
    end else if (key_wr) begin
      // block ahead was made with the old key
      pfv_nxt  = 1'b0;
      busy_nxt = 1'b0;
    end else if (ctl.take) begin
      ctr_nxt  = ctr_r + 128'd1;
      pfv_nxt  = 1'b0;
      busy_nxt = 1'b0;
    end else if (!pfv_r && !busy_r) begin
      st_nxt   = ctr_r ^ key;
      rk_nxt   = key;
      rcon_nxt = 8'h01;
      rnd_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      st_nxt   = mbac_pkg::aes_round(st_r, rk_step, last);
      rk_nxt   = rk_step;
      rcon_nxt = mbac_pkg::xt(rcon_r);
      rnd_nxt  = rnd_r + 4'd1;
      if (last) begin
        pf_nxt   = mbac_pkg::aes_round(st_r, rk_step, last);
        pfv_nxt  = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r  <= '0;
      busy_r <= 1'b0;
      pfv_r  <= 1'b0;
      rnd_r  <= 4'd0;
    end else begin
      ctr_r  <= ctr_nxt;
      busy_r <= busy_nxt;
      pfv_r  <= pfv_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    rk_r   <= rk_nxt;
    rcon_r <= rcon_nxt;
    pf_r   <= pf_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/mbac_back.sv
// back end: pulls keystream bits for the queue head and registers the result
// depends on mbac_pkg, mbac_out_if and the assertion header
`default_nettype none
`include "masked_bitplane_aes_ctr_unit_assert.svh"

module mbac_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  mbac_pkg::qent_t     head,
  output logic                pop,
  input  mbac_pkg::gen_stat_t gstat,
  output mbac_pkg::gen_ctl_t  gctl,
  mbac_out_if.source          out_ch
);

  logic [127:0] cur_r, cur_nxt;
  logic         cv_r, cv_nxt;
  logic [6:0]   pos_r, pos_nxt;
  logic         fdone_r, fdone_nxt;
  logic         ov_r, ov_nxt;
  logic [7:0]   res_r, res_nxt;

  logic         do_reload;
  logic [7:0]   off;
  logic [7:0]   total;
  logic         use_pf;
  logic [255:0] win;
  logic [7:0]   ks;
  logic [7:0]   bpos;
  logic [7:0]   v;
  logic         out_free;

  assign out_ch.valid       = ov_r;
  assign out_ch.result_byte = res_r;

  assign out_free  = !ov_r || out_ch.ready;
  assign do_reload = head_valid && head.first && !fdone_r;
  assign off       = cv_r ? {1'b0, pos_r} : 8'd0;
  assign total     = off + {4'd0, head.nbits};
  assign use_pf    = (head.nbits != 4'd0) &&
                     (!cv_r || (total > 8'(mbac_pkg::BLK_BITS)));
  assign pop       = head_valid && !do_reload && (!use_pf || gstat.pf_valid) && out_free;
  assign win       = cv_r ? {cur_r, gstat.pf} : {gstat.pf, 128'd0};

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      bpos  = 8'd255 - (off + 8'(j));
      ks[j] = win[bpos];
    end
    for (int p = 0; p < 8; p++) begin
      v[p] = head.data[p] ^ (head.en[p] & ks[head.idx[p]]);
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    cv_nxt      = cv_r;
    pos_nxt     = pos_r;
    fdone_nxt   = fdone_r;
    ov_nxt      = ov_r && !out_ch.ready;
    res_nxt     = res_r;
    gctl.take   = 1'b0;
    gctl.reload = 1'b0;
    if (do_reload) begin
      gctl.reload = 1'b1;
      cv_nxt      = 1'b0;
      pos_nxt     = 7'd0;
      fdone_nxt   = 1'b1;
    end else if (pop) begin
      ov_nxt    = 1'b1;
      res_nxt   = v;
      fdone_nxt = 1'b0;
      if (use_pf) begin
        // spill into the block ahead, it becomes the current one
        gctl.take = 1'b1;
        cur_nxt   = gstat.pf;
        cv_nxt    = 1'b1;
        pos_nxt   = cv_r ? 7'(total - 8'(mbac_pkg::BLK_BITS)) : 7'(total);
      end else if (cv_r && head.nbits != 4'd0) begin
        if (total == 8'(mbac_pkg::BLK_BITS)) begin
          cv_nxt  = 1'b0;
          pos_nxt = 7'd0;
        end else begin
          pos_nxt = 7'(total);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r    <= 1'b0;
      pos_r   <= 7'd0;
      fdone_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      cv_r    <= cv_nxt;
      pos_r   <= pos_nxt;
      fdone_r <= fdone_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  `MBAC_ASSERT_NOW(a_take_needs_pf, gctl.take, gstat.pf_valid, "keystream taken before ready")
  `MBAC_ASSERT_NEXT(a_reload_drops_cur, gctl.reload, !cv_r, "block kept across restart")
  `MBAC_ASSERT_NEXT(a_spill_sets_cur, pop && use_pf, cv_r && ov_r, "spill lost current block")
  `MBAC_ASSERT_NOW(a_no_pop_on_reload, gctl.reload, !pop, "restart and transfer together")

endmodule

`default_nettype wire
